// File: design/rcrm_pkg.sv
`default_nettype none

package rcrm_pkg;

    localparam int MAX_SLOTS_LOG2 = 10;
    localparam int SEQ_BITS       = 32;

    localparam int LG_W  = $clog2(MAX_SLOTS_LOG2 + 1);
    localparam int SZ_W  = MAX_SLOTS_LOG2 + 1;
    localparam int IDX_W = MAX_SLOTS_LOG2;
    localparam int CMP_BASE = (SEQ_BITS > 16) ? SEQ_BITS : 16;
    localparam int CMP_W = ((CMP_BASE > SZ_W) ? CMP_BASE : SZ_W) + 1;

    typedef logic [SEQ_BITS-1:0] seq_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOSPACE = 3'd1,
        ST_INVALID = 3'd2,
        ST_WAIT    = 3'd3,
        ST_SHORT   = 3'd4,
        ST_CROSS   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        FN_COUNT   = 3'd0,
        FN_RESERVE = 3'd1,
        FN_COMMIT  = 3'd2,
        FN_PEEK    = 3'd3,
        FN_POP     = 3'd4
    } func_t;

    localparam logic REG_SIZE_LOG2  = 1'b0;
    localparam logic REG_ELEM_SHIFT = 1'b1;

    localparam logic [10:0] CNT_SAT = 11'h7FF;

endpackage

`default_nettype wire

// File: design/reserve_commit_ring_manager_core.sv
`default_nettype none

// channel | signals                                        | handshake
// --------+------------------------------------------------+------------------
// in      | func amount in_bytes token                     | in_valid/in_ready
// out     | status token_out slot_index committed_count    | out_valid/out_ready
//         | slots_used                                     |
// cfg     | cfg_index cfg_wdata                            | cfg_we, no wait
//
// A request is captured in an input register and resolved combinationally into
// the result register; one request per cycle is sustained while out_ready is high.
// The sequence update and the result are produced by the same pass, so the
// next request sees the updated pointers without a bubble.
// Reset clears the three sequences and loads size_log2 = 10, elem_shift = 0.
// A stalled result holds the input register; in_ready drops only when both
// stages are full and out_ready is low.

module reserve_commit_ring_manager_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  func,
    input  wire logic [15:0] amount,
    input  wire logic        in_bytes,
    input  wire logic [31:0] token,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [31:0]      token_out,
    output logic [9:0]       slot_index,
    output logic [10:0]      committed_count,
    output logic [15:0]      slots_used,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [3:0]  cfg_wdata
);
    import rcrm_pkg::*;

    logic [3:0]  size_log2_reg;
    logic [3:0]  elem_shift_reg;
    seq_t        cs_reg, rs_reg, cm_reg;
    seq_t        cs_next, rs_next, cm_next;

    logic        in_valid_reg;
    logic [2:0]  func_reg;
    logic [15:0] amount_reg;
    logic        in_bytes_reg;
    logic [31:0] token_reg;

    logic        out_valid_reg;
    logic [2:0]  status_reg, status_next;
    logic [31:0] token_out_reg, token_out_next;
    logic [9:0]  slot_reg, slot_next;
    logic [10:0] cnt_reg, cnt_next;
    logic [15:0] used_reg, used_next;

    logic        advance;

    // derived ring geometry
    logic [LG_W-1:0]  lg;
    logic [SZ_W-1:0]  sz;
    logic [IDX_W-1:0] idx_mask;

    // request length in slots
    logic [16:0]      amt_sum;
    logic [15:0]      n;

    seq_t             tok;
    seq_t             used, d_res, d_tok, avail;
    logic [IDX_W-1:0] idx_rs, idx_cs, idx_pop;
    seq_t             base_rs, cs_pop, base_pop;
    logic             rs_jump, pop_jump;
    logic [CMP_W-1:0] n_w, sz_w;
    seq_t             cnt_raw;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign lg = (size_log2_reg > 4'(MAX_SLOTS_LOG2)) ? LG_W'(MAX_SLOTS_LOG2)
                                                      : LG_W'(size_log2_reg);
    assign sz       = SZ_W'(1) << lg;
    assign idx_mask = IDX_W'(sz - SZ_W'(1));

    assign amt_sum = 17'(amount_reg) + (17'(1) << elem_shift_reg) - 17'd1;
    assign n = !in_bytes_reg ? amount_reg
             : (amount_reg == 16'd0) ? 16'd0
             : 16'(amt_sum >> elem_shift_reg);

    assign tok   = seq_t'(token_reg);
    assign used  = rs_reg - cs_reg;
    assign d_res = rs_reg - cm_reg;
    assign d_tok = tok - cm_reg;
    assign avail = cm_reg - cs_reg;

    assign n_w  = CMP_W'(n);
    assign sz_w = CMP_W'(sz);

    assign idx_rs  = rs_reg[IDX_W-1:0] & idx_mask;
    assign idx_cs  = cs_reg[IDX_W-1:0] & idx_mask;
    assign base_rs = rs_reg + (seq_t'(sz) - seq_t'(idx_rs));
    // empty ring with all sequences equal, off a boundary
    assign rs_jump = (used == '0) && (cm_reg == rs_reg) && (idx_rs != '0);

    assign cs_pop   = cs_reg + seq_t'(n);
    assign idx_pop  = cs_pop[IDX_W-1:0] & idx_mask;
    assign base_pop = cs_pop + (seq_t'(sz) - seq_t'(idx_pop));
    assign pop_jump = (cs_pop == cm_reg) && (rs_reg == cs_pop) && (idx_pop != '0);

    always_comb
    begin
        cs_next        = cs_reg;
        rs_next        = rs_reg;
        cm_next        = cm_reg;
        status_next    = ST_OK;
        token_out_next = '0;
        slot_next      = '0;
        used_next      = n;
        case (func_reg)
            FN_COUNT:
            begin
                used_next = '0;
            end
            FN_RESERVE:
            begin
                if (n == 16'd0 || n_w > sz_w)
                    status_next = ST_INVALID;
                else if (CMP_W'(used) > sz_w - n_w)
                    status_next = ST_NOSPACE;
                else if (CMP_W'(idx_rs) + n_w > sz_w)
                begin
                    if (rs_jump)
                    begin
                        cs_next        = base_rs;
                        cm_next        = base_rs;
                        rs_next        = base_rs + seq_t'(n);
                        token_out_next = 32'(base_rs);
                        slot_next      = '0;
                    end
                    else
                        status_next = ST_CROSS;
                end
                else
                begin
                    rs_next        = rs_reg + seq_t'(n);
                    token_out_next = 32'(rs_reg);
                    slot_next      = 10'(idx_rs);
                end
            end
            FN_COMMIT:
            begin
                if (n == 16'd0 || n_w > sz_w || n_w > CMP_W'(d_res)
                    || CMP_W'(d_tok) > CMP_W'(d_res) - n_w)
                    status_next = ST_INVALID;
                else if (d_tok != '0)
                    status_next = ST_WAIT;
                else
                    cm_next = tok + seq_t'(n);
            end
            FN_PEEK:
            begin
                if (n == 16'd0)
                    status_next = ST_INVALID;
                else if (CMP_W'(avail) < n_w)
                    status_next = ST_SHORT;
                else if (CMP_W'(idx_cs) + n_w > sz_w)
                    status_next = ST_CROSS;
                else
                    slot_next = 10'(idx_cs);
            end
            FN_POP:
            begin
                if (n == 16'd0)
                    status_next = ST_INVALID;
                else if (CMP_W'(avail) < n_w)
                    status_next = ST_SHORT;
                else if (pop_jump)
                begin
                    cs_next = base_pop;
                    rs_next = base_pop;
                    cm_next = base_pop;
                end
                else
                    cs_next = cs_pop;
            end
            default:
            begin
                status_next = ST_INVALID;
                used_next   = '0;
            end
        endcase
        cnt_raw  = cm_next - cs_next;
        cnt_next = (CMP_W'(cnt_raw) > CMP_W'(CNT_SAT)) ? CNT_SAT : 11'(cnt_raw);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_log2_reg  <= 4'd10;
            elem_shift_reg <= 4'd0;
            cs_reg         <= '0;
            rs_reg         <= '0;
            cm_reg         <= '0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_SIZE_LOG2)
                    size_log2_reg <= cfg_wdata;
                else if (cfg_index == REG_ELEM_SHIFT)
                    elem_shift_reg <= cfg_wdata;
            end
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
            begin
                cs_reg <= cs_next;
                rs_reg <= rs_next;
                cm_reg <= cm_next;
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            func_reg     <= func;
            amount_reg   <= amount;
            in_bytes_reg <= in_bytes;
            token_reg    <= token;
        end
        if (advance)
        begin
            status_reg    <= status_next;
            token_out_reg <= token_out_next;
            slot_reg      <= slot_next;
            cnt_reg       <= cnt_next;
            used_reg      <= used_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign token_out       = token_out_reg;
    assign slot_index      = slot_reg;
    assign committed_count = cnt_reg;
    assign slots_used      = used_reg;

endmodule

`default_nettype wire

// File: design/rcrm_chk.sv
`default_nettype none

module rcrm_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  status,
    input wire logic [31:0] token_out,
    input wire logic [10:0] committed_count,
    input wire logic [15:0] slots_used
);
    import rcrm_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(token_out) && $stable(committed_count))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_CROSS)
        else $error("undefined status code");

    // pointers never hold more committed slots than the largest ring
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> committed_count <= 11'(1 << MAX_SLOTS_LOG2))
        else $error("committed count beyond ring size");

    // capacity and ordering failures only arise for nonzero lengths
    a_fail_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK && status != ST_INVALID |-> slots_used != 16'd0)
        else $error("failure status with zero length");

    a_token_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_out != 32'd0 |-> status == ST_OK)
        else $error("token granted on failed request");

endmodule

bind reserve_commit_ring_manager_core rcrm_chk u_rcrm_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .token_out       (token_out),
    .committed_count (committed_count),
    .slots_used      (slots_used)
);

`default_nettype wire

// File: bench/tb_reserve_commit_ring_manager_core.sv
`timescale 1ns / 100ps

module tb_reserve_commit_ring_manager_core;

    import rcrm_pkg::*;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 122;
    localparam int RESET_SIZE_LOG2 = 10;

    // function codes the block must reject
    localparam logic [2:0] FN_BAD_LO = 3'd5;
    localparam logic [2:0] FN_BAD_HI = 3'd7;

    typedef struct packed {
        status_t     status;
        logic [31:0] token_out;
        logic [9:0]  slot_index;
        logic [10:0] committed_count;
        logic [15:0] slots_used;
    } ring_reply_t;

    class ring_pointer_tracker;
        logic [3:0]  size_log2;
        logic [3:0]  elem_shift;
        logic [31:0] consume_ptr;
        logic [31:0] reserve_ptr;
        logic [31:0] commit_ptr;
        ring_reply_t expected_replies[$];
        int          mismatches;

        function new();
            size_log2   = 4'(RESET_SIZE_LOG2);
            elem_shift  = 4'd0;
            consume_ptr = 32'd0;
            reserve_ptr = 32'd0;
            commit_ptr  = 32'd0;
            mismatches  = 0;
        endfunction

        function logic [31:0] ring_slots();
            return 32'd1 << ((size_log2 > MAX_SLOTS_LOG2) ? MAX_SLOTS_LOG2 : size_log2);
        endfunction

        // Empty ring off a boundary: move every pointer up to the next boundary.
        function bit skip_to_boundary(logic [31:0] seq);
            logic [31:0] slots;
            logic [31:0] offset;
            logic [31:0] boundary;
            slots  = ring_slots();
            offset = seq & (slots - 32'd1);
            if (offset == 32'd0 || commit_ptr != seq || reserve_ptr != seq)
                return 1'b0;
            boundary    = seq + (slots - offset);
            reserve_ptr = boundary;
            commit_ptr  = boundary;
            if (consume_ptr == seq)
                consume_ptr = boundary;
            return 1'b1;
        endfunction

        function void note_request(logic [2:0] fn, logic [15:0] len, logic bytes_mode,
                                   logic [31:0] tok);
            ring_reply_t reply;
            logic [31:0] slots;
            logic [31:0] n;
            logic [31:0] used;
            logic [31:0] offset;
            logic [31:0] pending;
            logic [31:0] tok_dist;
            logic [31:0] avail;
            logic [31:0] held;
            bit          crossing;
            reply  = '0;
            reply.status = ST_OK;
            slots  = ring_slots();
            if (bytes_mode)
                n = (len == 16'd0) ? 32'd0 :
                    ({16'd0, len} + (32'd1 << elem_shift) - 32'd1) >> elem_shift;
            else
                n = {16'd0, len};

            if (fn == FN_COUNT) begin
                n = 32'd0;
            end else if (fn > FN_POP) begin
                n = 32'd0;
                reply.status = ST_INVALID;
            end else if (n == 32'd0) begin
                reply.status = ST_INVALID;
            end else if (fn == FN_RESERVE) begin
                if (n > slots) begin
                    reply.status = ST_INVALID;
                end else begin
                    used   = reserve_ptr - consume_ptr;
                    offset = reserve_ptr & (slots - 32'd1);
                    if (used > slots - n) begin
                        reply.status = ST_NOSPACE;
                    end else begin
                        crossing = (offset + n > slots);
                        if (crossing && used == 32'd0 && commit_ptr == reserve_ptr)
                            crossing = !skip_to_boundary(reserve_ptr);
                        if (crossing) begin
                            reply.status = ST_CROSS;
                        end else begin
                            reply.token_out  = reserve_ptr;
                            reply.slot_index = 10'(reserve_ptr & (slots - 32'd1));
                            reserve_ptr      = reserve_ptr + n;
                        end
                    end
                end
            end else if (fn == FN_COMMIT) begin
                pending  = reserve_ptr - commit_ptr;
                tok_dist = tok - commit_ptr;
                if (n > slots || n > pending || tok_dist > pending - n)
                    reply.status = ST_INVALID;
                else if (tok_dist != 32'd0)
                    reply.status = ST_WAIT;
                else
                    commit_ptr = tok + n;
            end else if (fn == FN_PEEK) begin
                avail  = commit_ptr - consume_ptr;
                offset = consume_ptr & (slots - 32'd1);
                if (avail < n)
                    reply.status = ST_SHORT;
                else if (offset + n > slots)
                    reply.status = ST_CROSS;
                else
                    reply.slot_index = 10'(offset);
            end else begin
                avail = commit_ptr - consume_ptr;
                if (avail < n) begin
                    reply.status = ST_SHORT;
                end else begin
                    consume_ptr = consume_ptr + n;
                    if (consume_ptr == commit_ptr)
                        void'(skip_to_boundary(consume_ptr));
                end
            end

            held = commit_ptr - consume_ptr;
            reply.committed_count = (held > 32'd2047) ? CNT_SAT : 11'(held);
            reply.slots_used      = n[15:0];
            expected_replies.push_back(reply);
        endfunction

        function void check_result(ring_reply_t got);
            ring_reply_t want;
            if (expected_replies.size() == 0) begin
                $error("result transaction with no request outstanding");
                mismatches++;
                return;
            end
            want = expected_replies.pop_front();
            if (got.status != want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.token_out != want.token_out) begin
                $error("token_out: expected %0h, got %0h", want.token_out, got.token_out);
                mismatches++;
            end
            if (got.slot_index != want.slot_index) begin
                $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
                mismatches++;
            end
            if (got.committed_count != want.committed_count) begin
                $error("committed_count: expected %0d, got %0d",
                       want.committed_count, got.committed_count);
                mismatches++;
            end
            if (got.slots_used != want.slots_used) begin
                $error("slots_used: expected %0d, got %0d", want.slots_used, got.slots_used);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  func;
    logic [15:0] amount;
    logic        in_bytes;
    logic [31:0] token;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [31:0] token_out;
    logic [9:0]  slot_index;
    logic [10:0] committed_count;
    logic [15:0] slots_used;
    logic        cfg_we;
    logic        cfg_index;
    logic [3:0]  cfg_wdata;

    ring_pointer_tracker pointers;
    int max_gap = 4;

    int phase_size_log2  [PHASES] = '{2, 0, 15, 3, 1, 10, 4, 5};
    int phase_elem_shift [PHASES] = '{0, 15, 3, 12, 0, 7, 13, 1};

    reserve_commit_ring_manager_core DUT (.*);

    always #4 clk = ~clk;

    task automatic send_request(logic [2:0] fn, logic [15:0] len, logic bytes_mode,
                                logic [31:0] tok);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= fn;
        amount   <= len;
        in_bytes <= bytes_mode;
        token    <= tok;
        // ready as seen at the edge itself, before the block updates
        @(posedge clk iff in_ready);
        pointers.note_request(fn, len, bytes_mode, tok);
    endtask

    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (pointers.expected_replies.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_ring_config(logic [3:0] lg, logic [3:0] shift);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SIZE_LOG2;
        cfg_wdata <= lg;
        @(posedge clk);
        pointers.size_log2 = lg;
        cfg_index <= REG_ELEM_SHIFT;
        cfg_wdata <= shift;
        @(posedge clk);
        pointers.elem_shift = shift;
        cfg_we <= 1'b0;
    endtask

    // commit everything reserved, then consume everything committed
    task automatic flush_ring();
        logic [31:0] outstanding;
        outstanding = pointers.reserve_ptr - pointers.commit_ptr;
        if (outstanding != 32'd0)
            send_request(FN_COMMIT, outstanding[15:0], 1'b0, pointers.commit_ptr);
        outstanding = pointers.commit_ptr - pointers.consume_ptr;
        if (outstanding != 32'd0)
            send_request(FN_POP, outstanding[15:0], 1'b0, $urandom());
    endtask

    task automatic send_random_request();
        int unsigned pick;
        logic [2:0]  fn;
        logic [31:0] n;
        logic [31:0] tok;
        logic [31:0] slots;
        logic [31:0] offset;
        logic [31:0] pending;
        logic [31:0] avail;
        logic [31:0] k;
        logic [31:0] bytes;
        logic        bytes_mode;
        pick       = $urandom_range(0, 99);
        slots      = pointers.ring_slots();
        pending    = pointers.reserve_ptr - pointers.commit_ptr;
        avail      = pointers.commit_ptr - pointers.consume_ptr;
        offset     = pointers.reserve_ptr & (slots - 32'd1);
        tok        = $urandom();
        n          = 32'd1;
        bytes_mode = 1'b0;
        fn         = FN_COUNT;

        if (pick < 6) begin
            // noise: any code, any payload
            fn         = 3'($urandom());
            n          = $urandom() & 32'hFFFF;
            bytes_mode = 1'($urandom());
        end else if (pick < 10) begin
            fn = FN_COUNT;
        end else if (pick < 35) begin
            fn = FN_RESERVE;
            if (pick < 13)
                n = slots + 32'd1 + $urandom_range(0, 3);
            else if (pick < 19 && offset != 32'd0)
                n = $urandom_range(slots - offset + 32'd1, slots);
            else if (slots > 32'd8 && pick < 30)
                n = $urandom_range(1, 8);
            else
                n = $urandom_range(1, slots);
        end else if (pick < 60) begin
            fn = FN_COMMIT;
            if (pending == 32'd0 || pick >= 56) begin
                n = $urandom_range(1, slots + 32'd1);
            end else if (pick < 51 || pending < 32'd2) begin
                tok = pointers.commit_ptr;
                n   = $urandom_range(1, pending);
            end else begin
                // a later run that is not yet its turn
                k   = $urandom_range(1, pending - 32'd1);
                tok = pointers.commit_ptr + k;
                n   = $urandom_range(1, pending - k);
            end
        end else if (pick < 75) begin
            fn = FN_PEEK;
            n  = $urandom_range(1, avail + 32'd1);
        end else begin
            fn = FN_POP;
            if (avail == 32'd0 || pick >= 96)
                n = avail + 32'd1;
            else if (pick < 85)
                n = avail;
            else
                n = $urandom_range(1, avail);
        end

        if (pick >= 6 && $urandom_range(0, 4) == 0) begin
            bytes = ((n - 32'd1) << pointers.elem_shift)
                    + $urandom_range(1, 32'd1 << pointers.elem_shift);
            if (bytes <= 32'hFFFF) begin
                bytes_mode = 1'b1;
                n          = bytes;
            end
        end
        if (pick >= 6 && $urandom_range(0, 49) == 0)
            n = 32'd0;
        send_request(fn, n[15:0], bytes_mode, tok);
    endtask

    initial begin : result_sink
        ring_reply_t got;
        int          stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = $urandom_range(0, max_gap);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            // sample the result as it stands at the accepting edge
            @(posedge clk iff out_valid);
            got.status          = status_t'(status);
            got.token_out       = token_out;
            got.slot_index      = slot_index;
            got.committed_count = committed_count;
            got.slots_used      = slots_used;
            pointers.check_result(got);
        end
    end

    initial begin
        #1_000_000;
        $display("FAIL reserve_commit_ring_manager_core");
        $finish;
    end

    initial begin
        pointers = new();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        func      <= FN_COUNT;
        amount    <= 16'd0;
        in_bytes  <= 1'b0;
        token     <= 32'd0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_SIZE_LOG2;
        cfg_wdata <= 4'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: 1024 slots, byte stride 1
        send_request(FN_COUNT, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
        send_request(FN_BAD_LO, 16'd7, 1'b0, 32'd0);
        send_request(FN_BAD_HI, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
        send_request(FN_RESERVE, 16'd0, 1'b0, 32'd0);
        send_request(FN_RESERVE, 16'd1025, 1'b0, 32'd0);
        send_request(FN_RESERVE, 16'd1000, 1'b0, 32'd0);
        send_request(FN_RESERVE, 16'd100, 1'b0, 32'd0);
        send_request(FN_COMMIT, 16'd10, 1'b0, 32'd5);
        send_request(FN_COMMIT, 16'd1, 1'b0, 32'hFFFF_FFFF);
        send_request(FN_COMMIT, 16'd1025, 1'b0, 32'd0);
        send_request(FN_PEEK, 16'd1, 1'b0, 32'd0);
        send_request(FN_COMMIT, 16'd1000, 1'b0, 32'd0);
        send_request(FN_PEEK, 16'd1000, 1'b0, 32'd0);
        send_request(FN_POP, 16'd1001, 1'b0, 32'd0);
        send_request(FN_POP, 16'd1000, 1'b0, 32'd0);

        // oversized size register, widest stride
        wait_until_drained();
        write_ring_config(4'd15, 4'd15);
        send_request(FN_RESERVE, 16'd0, 1'b1, 32'd0);
        send_request(FN_RESERVE, 16'hFFFF, 1'b1, 32'd0);

        // four-slot ring: committed data that wraps past the end
        wait_until_drained();
        write_ring_config(4'd2, 4'd12);
        send_request(FN_COMMIT, 16'd2, 1'b0, 32'd1024);
        send_request(FN_POP, 16'd1, 1'b0, 32'd0);
        send_request(FN_RESERVE, 16'd1, 1'b0, 32'd0);
        send_request(FN_RESERVE, 16'd1, 1'b0, 32'd0);
        send_request(FN_RESERVE, 16'd1, 1'b0, 32'd0);
        send_request(FN_COMMIT, 16'd3, 1'b0, 32'd1026);
        send_request(FN_PEEK, 16'd4, 1'b0, 32'd0);
        send_request(FN_PEEK, 16'd3, 1'b0, 32'd0);

        for (int p = 0; p < PHASES; p++) begin
            wait_until_drained();
            write_ring_config(4'(phase_size_log2[p]), 4'(phase_elem_shift[p]));
            max_gap = (p % 3 == 2) ? 0 : 4;
            repeat (ITEMS_PER_PHASE) send_random_request();
            flush_ring();
        end
        max_gap = 4;
        wait_until_drained();

        if (pointers.mismatches == 0)
            $display("PASS reserve_commit_ring_manager_core");
        else
            $display("FAIL reserve_commit_ring_manager_core");
        $finish;
    end

endmodule
